// ===== src/mie_pkg.sv =====
// Shared constants and state types for the modular inverse unit.
package mie_pkg;

  localparam int WORD_BITS_DEFAULT = 64;
  localparam int FIELD_BITS = 64;
  localparam int ADDR_BITS = 4;
  localparam logic REG_MODULUS = 1'b0;
  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 64'd1;

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_DIV  = 3'b010,
    A_MUL  = 3'b100
  } arith_state_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_VSTEP = 4'b0010,
    S_USTEP = 4'b0100,
    S_DONE  = 4'b1000
  } seq_state_t;

endpackage

// ===== src/mie_arith.sv =====
// Shared divide and multiply-accumulate unit: r = a mod b, acc = c + (a / b) * d.
module mie_arith #(
  parameter int WORD_BITS = mie_pkg::WORD_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  logic [WORD_BITS-1:0] c,
  input  logic [WORD_BITS-1:0] d,
  output logic                 done,
  output logic [WORD_BITS-1:0] rem,
  output logic [WORD_BITS-1:0] acc
);

  localparam int CNT_W = $clog2(WORD_BITS);

  mie_pkg::arith_state_t state;
  logic [CNT_W-1:0]     cnt;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] divisor;
  logic [WORD_BITS-1:0] mul;
  logic [WORD_BITS:0]   rem_sh;
  logic                 fits;

  assign rem_sh = {rem, quo[WORD_BITS-1]};
  assign fits   = rem_sh >= {1'b0, divisor};
  assign done   = (state == mie_pkg::A_MUL) && (quo == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mie_pkg::A_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        mie_pkg::A_IDLE: begin
          if (start) begin
            state <= mie_pkg::A_DIV;
            cnt   <= '0;
          end
        end
        mie_pkg::A_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(WORD_BITS - 1)) begin
            state <= mie_pkg::A_MUL;
          end
        end
        mie_pkg::A_MUL: begin
          // The next round may start in the cycle that this one finishes.
          if (quo == '0) begin
            if (start) begin
              state <= mie_pkg::A_DIV;
              cnt   <= '0;
            end else begin
              state <= mie_pkg::A_IDLE;
            end
          end
        end
        default: state <= mie_pkg::A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state == mie_pkg::A_IDLE || done)) begin
      rem     <= '0;
      quo     <= a;
      divisor <= b;
      acc     <= c;
      mul     <= d;
    end else if (state == mie_pkg::A_DIV) begin
      // One restoring step: the quotient bit shifts in where the dividend leaves.
      rem <= fits ? WORD_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[WORD_BITS-1:0];
      quo <= {quo[WORD_BITS-2:0], fits};
    end else if (state == mie_pkg::A_MUL && quo != '0) begin
      if (quo[0]) begin
        acc <= acc + mul;
      end
      quo <= quo >> 1;
      mul <= mul << 1;
    end
  end

endmodule

// ===== src/modular_inverse_ext_euclid_unit.sv =====
// Modular inverse by the extended Euclidean algorithm, top level with sequencer.
// Usage:
//   Write the modulus over the APB port at byte address 0 (64-bit data) while
//   the block is idle; reset sets it to 1. A request on the input channel
//   (in_valid high, in_stall low) carries one value. The block then holds
//   in_stall high until its result has been taken on the output channel.
//   The result gives inverse = value^-1 mod modulus and invertible = 1, or
//   0 and 0 when the value is zero, not below the modulus, or shares a factor
//   with it. Zero, one and out-of-range values present their result in the
//   cycle after the request is taken. Otherwise each Euclid round runs on one
//   shared divide and multiply unit: a restoring division over WORD_BITS
//   quotient bits, a shift-and-add multiply over the bits of the quotient,
//   and a hand-over to the next round. 64-bit operands take up to about
//   ninety rounds. A new request is taken only after the result has been
//   taken and the block is idle again.
//   out_valid stays high and the result stays unchanged while out_stall is
//   high. Reset clears the sequencer and drops out_valid; the modulus
//   returns to 1.
module modular_inverse_ext_euclid_unit #(
  parameter int WORD_BITS = mie_pkg::WORD_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mie_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [mie_pkg::FIELD_BITS-1:0]    pwdata,
  output logic [mie_pkg::FIELD_BITS-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mie_pkg::FIELD_BITS-1:0]    value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mie_pkg::FIELD_BITS-1:0]    inverse,
  output logic                              invertible
);

  localparam int FB = mie_pkg::FIELD_BITS;

  mie_pkg::seq_state_t  state;
  logic [FB-1:0]        modulus;
  logic [WORD_BITS-1:0] t, s;
  logic [WORD_BITS-1:0] ur, ua, vr, vb;
  logic [WORD_BITS-1:0] res;
  logic                 ok;

  logic                 ar_start;
  logic [WORD_BITS-1:0] ar_a, ar_b, ar_c, ar_d;
  logic                 ar_done;
  logic [WORD_BITS-1:0] ar_rem, ar_acc;
  logic                 accept;
  logic                 reg_sel;

  assign pready   = 1'b1;
  assign reg_sel  = paddr[mie_pkg::ADDR_BITS-1];
  assign prdata   = (reg_sel == mie_pkg::REG_MODULUS) ? modulus : '0;
  assign t        = modulus[WORD_BITS-1:0];
  assign s        = value[WORD_BITS-1:0];
  assign accept   = in_valid && (state == mie_pkg::S_IDLE);
  assign in_stall = (state != mie_pkg::S_IDLE);
  assign out_valid  = (state == mie_pkg::S_DONE);
  assign inverse    = FB'(res);
  assign invertible = ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mie_pkg::MODULUS_RESET;
    end else if (psel && penable && pwrite && reg_sel == mie_pkg::REG_MODULUS) begin
      modulus <= pwdata;
    end
  end

  // Operands for the next step come straight from the unit's results where needed.
  always_comb begin
    ar_start = 1'b0;
    ar_a = t;
    ar_b = s;
    ar_c = '0;
    ar_d = WORD_BITS'(1);
    unique case (state)
      mie_pkg::S_IDLE: begin
        ar_start = accept && s > WORD_BITS'(1) && s < t;
      end
      mie_pkg::S_VSTEP: begin
        ar_start = ar_done && ar_rem > WORD_BITS'(1);
        ar_a = ur;
        ar_b = ar_rem;
        ar_c = ua;
        ar_d = ar_acc;
      end
      mie_pkg::S_USTEP: begin
        ar_start = ar_done && ar_rem != '0;
        ar_a = vr;
        ar_b = ar_rem;
        ar_c = vb;
        ar_d = ar_acc;
      end
      mie_pkg::S_DONE: ar_start = 1'b0;
      default: ar_start = 1'b0;
    endcase
  end

  mie_arith #(.WORD_BITS(WORD_BITS)) u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (ar_start),
    .a     (ar_a),
    .b     (ar_b),
    .c     (ar_c),
    .d     (ar_d),
    .done  (ar_done),
    .rem   (ar_rem),
    .acc   (ar_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mie_pkg::S_IDLE;
    end else begin
      unique case (state)
        mie_pkg::S_IDLE: begin
          if (accept) begin
            state <= ar_start ? mie_pkg::S_VSTEP : mie_pkg::S_DONE;
          end
        end
        mie_pkg::S_VSTEP: begin
          if (ar_done) begin
            state <= ar_start ? mie_pkg::S_USTEP : mie_pkg::S_DONE;
          end
        end
        mie_pkg::S_USTEP: begin
          if (ar_done) begin
            state <= ar_start ? mie_pkg::S_VSTEP : mie_pkg::S_DONE;
          end
        end
        mie_pkg::S_DONE: begin
          if (!out_stall) begin
            state <= mie_pkg::S_IDLE;
          end
        end
        default: state <= mie_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mie_pkg::S_IDLE: begin
        ur <= s;
        ua <= WORD_BITS'(1);
        ok  <= (s == WORD_BITS'(1)) && (s < t);
        res <= ((s == WORD_BITS'(1)) && (s < t)) ? WORD_BITS'(1) : '0;
      end
      mie_pkg::S_VSTEP: begin
        if (ar_done) begin
          vr <= ar_rem;
          vb <= ar_acc;
          // A zero remainder ends with gcd ur; a unit remainder gives -vb.
          if (ar_rem == '0) begin
            ok  <= (ur == WORD_BITS'(1));
            res <= (ur == WORD_BITS'(1)) ? ua : '0;
          end else if (ar_rem == WORD_BITS'(1)) begin
            ok  <= 1'b1;
            res <= t - ar_acc;
          end
        end
      end
      mie_pkg::S_USTEP: begin
        if (ar_done) begin
          ur <= ar_rem;
          ua <= ar_acc;
          if (ar_rem == '0) begin
            ok  <= (vr == WORD_BITS'(1));
            res <= (vr == WORD_BITS'(1)) ? t - vb : '0;
          end
        end
      end
      mie_pkg::S_DONE: res <= res;
      default: res <= res;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");
  a_zero_when_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !invertible) |-> (inverse == '0))
    else $error("non-invertible result carries a nonzero inverse");
  a_unit_idle_outside: assert property (@(posedge clk) disable iff (rst)
    ar_done |-> (state == mie_pkg::S_VSTEP || state == mie_pkg::S_USTEP))
    else $error("arithmetic unit finished outside a Euclid step");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(inverse) && $stable(invertible)))
    else $error("stalled result changed");
`endif

endmodule
